/* rtl/font_table_directory_checker_assert.svh */
// Assertion macros for the font table directory checker.
`ifndef FONT_TABLE_DIRECTORY_CHECKER_ASSERT_SVH
`define FONT_TABLE_DIRECTORY_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF

`define FDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define FDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FDC_ASSERT_IMPL(lbl, ante, cons, msg)

`define FDC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/fdc_pkg.sv */
// Types and constants shared by the font table directory checker.
`timescale 1ns / 1ps
package fdc_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned COUNT_POS    = 4;
  localparam int unsigned RECORD_SHIFT = 4;

  localparam logic [1:0] REC_START_QUAD  = 2'd2;
  localparam logic [1:0] REC_LENGTH_QUAD = 2'd3;
  localparam logic [3:0] REC_LAST_BYTE   = 4'd15;

  localparam logic [1:0] V_WHOLE        = 2'd0;
  localparam logic [1:0] V_SHORT_HEADER = 2'd1;
  localparam logic [1:0] V_SHORT_DIR    = 2'd2;
  localparam logic [1:0] V_TABLE_PAST   = 2'd3;

  localparam logic REG_FILE_LENGTH = 1'b0;
  localparam logic REG_FONT_START  = 1'b1;

  typedef struct packed {
    logic [31:0] file_length;
    logic [31:0] font_start;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_of_file;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  verdict;
    logic [15:0] bad_table;
  } res_t;

  typedef struct packed {
    logic take;
    logic res_valid;
    logic verdict_given;
  } scan_st_t;

endpackage

/* rtl/fdc_in_if.sv */
// Input byte channel of the font table directory checker.
`timescale 1ns / 1ps
interface fdc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_file;

  modport source (output valid, data_byte, first_of_file, input ready);
  modport sink (input valid, data_byte, first_of_file, output ready);
endinterface

/* rtl/fdc_out_if.sv */
// Verdict channel of the font table directory checker.
`timescale 1ns / 1ps
interface fdc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [15:0] bad_table;

  modport source (output valid, verdict, bad_table, input ready);
  modport sink (input valid, verdict, bad_table, output ready);
endinterface

/* rtl/fdc_cfg.sv */
// APB configuration registers for file length and font start.
`timescale 1ns / 1ps
module fdc_cfg (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output fdc_pkg::cfg_t cfg
);
  import fdc_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (paddr[2])
        REG_FILE_LENGTH: cfg_r.file_length <= pwdata;
        REG_FONT_START:  cfg_r.font_start  <= pwdata;
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_FILE_LENGTH: prdata = cfg_r.file_length;
      REG_FONT_START:  prdata = cfg_r.font_start;
      default:         prdata = '0;
    endcase
  end

  assign cfg = cfg_r;
endmodule

/* rtl/fdc_in_reg.sv */
// Input register stage for incoming font bytes.
`timescale 1ns / 1ps
module fdc_in_reg (
  input  logic           clk,
  input  logic           rst_n,
  fdc_in_if.sink         in_ch,
  input  logic           take,
  output fdc_pkg::item_t item,
  output logic           item_vld
);
  import fdc_pkg::*;

  item_t item_r;
  logic  vld_r;
  logic  load;

  assign in_ch.ready = !vld_r || take;
  assign load        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.data_byte     <= in_ch.data_byte;
      item_r.first_of_file <= in_ch.first_of_file;
    end
  end

  assign item     = item_r;
  assign item_vld = vld_r;
endmodule

/* rtl/fdc_scan.sv */
// Scan state and per-byte bounds checks of the table directory.
`timescale 1ns / 1ps
module fdc_scan (
  input  logic              clk,
  input  logic              rst_n,
  input  fdc_pkg::cfg_t     cfg,
  input  fdc_pkg::item_t    item,
  input  logic              item_vld,
  input  logic              out_free,
  output fdc_pkg::res_t     res,
  output fdc_pkg::scan_st_t st
);
  import fdc_pkg::*;

  logic [31:0] pos_r, pos_nxt, pos;
  logic [15:0] tot_r, tot_nxt, tot;
  logic [15:0] rn_r, rn_nxt, rn;
  logic [3:0]  rb_r, rb_nxt, rb;
  logic [31:0] sacc_r, sacc_nxt, sacc;
  logic [31:0] lacc_r, lacc_nxt, lacc;
  logic        vg_r, vg_nxt, vg;
  logic        take;
  logic [31:0] rel;
  logic [15:0] tot_new;
  logic [15:0] rn_inc;
  logic [33:0] dir_end;
  logic [32:0] tab_end;
  logic [32:0] hdr_end;

  assign take = item_vld && out_free;

  always_comb begin
    pos  = item.first_of_file ? '0 : pos_r;
    tot  = item.first_of_file ? '0 : tot_r;
    rn   = item.first_of_file ? '0 : rn_r;
    rb   = item.first_of_file ? '0 : rb_r;
    sacc = item.first_of_file ? '0 : sacc_r;
    lacc = item.first_of_file ? '0 : lacc_r;
    vg   = item.first_of_file ? 1'b0 : vg_r;

    pos_nxt  = pos;
    tot_nxt  = tot;
    rn_nxt   = rn;
    rb_nxt   = rb;
    sacc_nxt = sacc;
    lacc_nxt = lacc;
    vg_nxt   = vg;
    res      = '0;

    rel     = pos - cfg.font_start;
    tot_new = tot | {8'h00, item.data_byte};
    rn_inc  = rn + 16'd1;
    hdr_end = {1'b0, cfg.font_start} + 33'(HEADER_BYTES);
    dir_end = {2'b00, cfg.font_start} + 34'(HEADER_BYTES)
              + ({18'd0, tot_new} << RECORD_SHIFT);
    tab_end = 33'd0;

    if (!vg) begin
      pos_nxt = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
      if (pos == 32'd0 && hdr_end > {1'b0, cfg.file_length}) begin
        res = '{valid: 1'b1, verdict: V_SHORT_HEADER, bad_table: 16'd0};
      end else if (pos >= cfg.font_start) begin
        if (rel == 32'(COUNT_POS)) begin
          tot_nxt = {item.data_byte, 8'h00};
        end else if (rel == 32'(COUNT_POS + 1)) begin
          tot_nxt = tot_new;
          if (dir_end > {2'b00, cfg.file_length}) begin
            res = '{valid: 1'b1, verdict: V_SHORT_DIR, bad_table: 16'd0};
          end else if (tot_new == 16'd0) begin
            res = '{valid: 1'b1, verdict: V_WHOLE, bad_table: 16'd0};
          end
        end else if (rel >= 32'(HEADER_BYTES)) begin
          if (rb[3:2] == REC_START_QUAD) begin
            sacc_nxt = {sacc[23:0], item.data_byte};
          end else if (rb[3:2] == REC_LENGTH_QUAD) begin
            lacc_nxt = {lacc[23:0], item.data_byte};
          end
          tab_end = {1'b0, sacc_nxt} + {1'b0, lacc_nxt};
          if (rb == REC_LAST_BYTE) begin
            rb_nxt = '0;
            if (tab_end > {1'b0, cfg.file_length}) begin
              res = '{valid: 1'b1, verdict: V_TABLE_PAST, bad_table: rn};
            end else begin
              rn_nxt = rn_inc;
              if (rn_inc >= tot) begin
                res = '{valid: 1'b1, verdict: V_WHOLE, bad_table: 16'd0};
              end
            end
          end else begin
            rb_nxt = rb + 4'd1;
          end
        end
      end
      if (res.valid) begin
        vg_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tot_r  <= '0;
      rn_r   <= '0;
      rb_r   <= '0;
      sacc_r <= '0;
      lacc_r <= '0;
      vg_r   <= 1'b0;
    end else if (take) begin
      pos_r  <= pos_nxt;
      tot_r  <= tot_nxt;
      rn_r   <= rn_nxt;
      rb_r   <= rb_nxt;
      sacc_r <= sacc_nxt;
      lacc_r <= lacc_nxt;
      vg_r   <= vg_nxt;
    end
  end

  assign st = '{take: take, res_valid: res.valid, verdict_given: vg_r};
endmodule

/* rtl/fdc_out_reg.sv */
// Output register holding one verdict word for the receiver.
`timescale 1ns / 1ps
module fdc_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  fdc_pkg::res_t res,
  input  logic          take,
  output logic          out_free,
  fdc_out_if.source     out_ch
);
  import fdc_pkg::*;

  res_t res_r;
  logic vld_r;
  logic load;

  assign out_free = !vld_r || out_ch.ready;
  assign load     = take && res.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = vld_r;
  assign out_ch.verdict   = res_r.verdict;
  assign out_ch.bad_table = res_r.bad_table;
endmodule

/* rtl/font_table_directory_checker.sv */
// Font table directory checker: usage notes.
// in_ch carries a font file one byte per word, byte zero flagged by
// first_of_file; out_ch carries at most one verdict word per file
// (verdict and bad_table). File length and font start are written over
// the APB port at byte addresses 0 and 4 while the block is idle.
// The byte that settles a verdict passes the input register, then the
// verdict register, which drives out_ch.valid.
// Throughput: one byte per cycle while the verdict register is free;
// the scan state updates once per byte in a single pass through a
// 34-bit add and compare.
// Reset clears the scan state and both valid flags; the first byte
// after reset counts as byte zero. After a verdict, bytes are dropped
// until the next first_of_file. When the receiver stalls, the verdict
// word holds, at most one more byte is accepted into the input register
// and then in_ch.ready stays low until the verdict word is taken.
`timescale 1ns / 1ps
`include "font_table_directory_checker_assert.svh"
module font_table_directory_checker (
  input  logic        clk,
  input  logic        rst_n,
  fdc_in_if.sink      in_ch,
  fdc_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import fdc_pkg::*;

  cfg_t     cfg;
  item_t    item;
  logic     item_vld;
  logic     out_free;
  res_t     res;
  scan_st_t scan_st;

  fdc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fdc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (scan_st.take),
    .item     (item),
    .item_vld (item_vld)
  );

  fdc_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item     (item),
    .item_vld (item_vld),
    .out_free (out_free),
    .res      (res),
    .st       (scan_st)
  );

  fdc_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .res      (res),
    .take     (scan_st.take),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

  `FDC_ASSERT_IMPL(a_bad_table_only_past,
                   out_ch.valid && out_ch.verdict != V_TABLE_PAST,
                   out_ch.bad_table == 16'd0,
                   "bad_table set without table-past verdict")
  `FDC_ASSERT_NEXT(a_verdict_latched,
                   scan_st.take && scan_st.res_valid,
                   scan_st.verdict_given,
                   "verdict flag not set after verdict")
  `FDC_ASSERT_NEXT(a_verdict_shown,
                   scan_st.take && scan_st.res_valid,
                   out_ch.valid,
                   "verdict word not presented")
endmodule
